// ----- rtl/apd_pkg.sv -----
// Shared types, constants and the CRC-8 step function of the packet deframer.
package apd_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 7;
  localparam int IdxW    = 6;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEER_ADDR   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CRC_POLY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CRC_SEED    = 3'd4;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_DATA    = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KindW-1:0] KIND_CRC_ERR = 2'd2;

  // Reset values of the registers that do not reset to zero.
  localparam logic [LenW-1:0]  MAX_PAYLOAD_RST = 7'd32;
  localparam logic [ByteW-1:0] CRC_POLY_RST    = 8'd7;

  // One finished frame, handed from the parser to the result side.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] seq;
    logic [ByteW-1:0] ptype;
    logic [LenW-1:0]  len;
    logic             bank;
  } cmd_t;

  // The result side is done reading one payload bank.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

  // One byte through an MSB-first CRC-8 with no reflection.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b,
                                                   input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/apd_if.sv -----
// Valid/ready channel interfaces for received bytes and result words.
interface apd_in_if;
  logic                     valid;
  logic                     ready;
  logic [apd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface apd_out_if;
  logic                      valid;
  logic                      ready;
  logic [apd_pkg::KindW-1:0] kind;
  logic [apd_pkg::ByteW-1:0] seq_num;
  logic [apd_pkg::ByteW-1:0] packet_type;
  logic [apd_pkg::LenW-1:0]  payload_len;
  logic [apd_pkg::IdxW-1:0]  byte_index;
  logic [apd_pkg::ByteW-1:0] data_byte;
  logic                      last;

  modport source (output valid, output kind, output seq_num, output packet_type,
                  output payload_len, output byte_index, output data_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input seq_num, input packet_type,
                input payload_len, input byte_index, input data_byte,
                input last, output ready);
endinterface

// ----- rtl/addressed_packet_deframer_crc8.sv -----
// Top level of the addressed packet deframer with CRC-8 check.
//
// Received bytes enter on the rx channel, one word per cycle at most; the
// parser walks destination, source, sequence, type, length, payload and CRC.
// Each good frame yields one result word per payload byte, or one empty-packet
// word; a frame with a bad CRC yields one error word. Results leave on the
// result channel with last set on the final word of a frame.
// Registers are written through wr_en, wr_index and wr_data; they are to be
// written only while idle, which the block itself does not enforce. A result
// word passes the frame queue, the registered read of the payload RAM and the
// output register; a new RAM read waits until the previous one is back.
// The payload RAM holds two banks, so a frame can be received while the
// previous one is still read out. A payload byte waits only while both banks
// hold unread frames, and a CRC byte waits while the two-entry frame queue
// is full; otherwise rx accepts a byte every cycle.
// When the receiver stalls, the output register holds its word and the
// queue and banks fill up before rx is held off.
// Reset (synchronous, active high) returns the parser to the destination
// hunt, empties the queue and loads the register defaults; the RAM is not
// cleared, since only bytes written in the current frame are read.
module addressed_packet_deframer_crc8 #(
  parameter int MAX_DATA = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  apd_in_if.sink                      rx,
  apd_out_if.source                   result,
  input  logic                        wr_en,
  input  logic [apd_pkg::CfgIdxW-1:0] wr_index,
  input  logic [apd_pkg::ByteW-1:0]   wr_data
);
  import apd_pkg::*;

  localparam int IW       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int RamDepth = 2 * (2 ** IW);

  logic       push;
  cmd_t       push_cmd;
  logic       q_ready;
  logic       pop;
  logic       head_valid;
  cmd_t       head;
  bank_free_t bank_free;

  logic             ram_we;
  logic [IW:0]      ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [IW:0]      ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  apd_front #(
    .MAX_DATA (MAX_DATA),
    .IW       (IW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_ready   (q_ready),
    .bank_free (bank_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  apd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  apd_ram #(
    .WIDTH (ByteW),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  apd_back #(
    .IW (IW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .bank_free  (bank_free),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .result     (result)
  );

endmodule

// ----- rtl/apd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module apd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/apd_front.sv -----
// Frame parser: walks the header, stores the payload, checks the CRC.
module apd_front #(
  parameter int MAX_DATA = 64,
  parameter int IW       = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  apd_in_if.sink                        rx,
  input  logic                          wr_en,
  input  logic [apd_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [apd_pkg::ByteW-1:0]     wr_data,
  output logic                          push,
  output apd_pkg::cmd_t                 push_cmd,
  input  logic                          q_ready,
  input  apd_pkg::bank_free_t           bank_free,
  output logic                          ram_we,
  output logic [IW:0]                   ram_waddr,
  output logic [apd_pkg::ByteW-1:0]     ram_wdata
);
  import apd_pkg::*;

  typedef enum logic [2:0] {
    PH_DST, PH_SRC, PH_SEQ, PH_TYPE, PH_LEN, PH_DATA, PH_CRC
  } phase_t;

  phase_t           phase;
  logic [ByteW-1:0] own_address;
  logic [ByteW-1:0] peer_address;
  logic [LenW-1:0]  max_payload;
  logic [ByteW-1:0] crc_poly;
  logic [ByteW-1:0] crc_seed;
  logic [ByteW-1:0] held_seq;
  logic [ByteW-1:0] held_type;
  logic [LenW-1:0]  held_len;
  logic [LenW-1:0]  payload_count;
  logic [ByteW-1:0] running_crc;
  logic             wbank;
  logic [1:0]       busy;

  logic             accept;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] crc_in;
  logic [ByteW-1:0] crc_new;
  logic [LenW-1:0]  limit;
  logic [LenW-1:0]  count_next;
  logic [1:0]       busy_set;
  logic [1:0]       busy_clr;

  // Hold off payload bytes while the bank is still being read out, and the
  // CRC byte while the queue is full.
  assign rx.ready = !((phase == PH_DATA) && busy[wbank]) &&
                    !((phase == PH_CRC) && !q_ready);
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // CRC step; the seed is loaded at the sequence byte.
  assign crc_in  = (phase == PH_SEQ) ? crc_seed : running_crc;
  assign crc_new = crc8_update(crc_in, b, crc_poly);

  // Length limit saturates at MAX_DATA.
  assign limit      = (max_payload > LenW'(MAX_DATA)) ? LenW'(MAX_DATA) : max_payload;
  assign count_next = payload_count + 1'b1;

  // Payload bytes go straight into the current bank.
  assign ram_we    = accept && (phase == PH_DATA);
  assign ram_waddr = {wbank, payload_count[IW-1:0]};
  assign ram_wdata = b;

  // Frame verdict at the CRC byte.
  always_comb begin
    push              = accept && (phase == PH_CRC);
    push_cmd.seq      = held_seq;
    push_cmd.ptype    = held_type;
    push_cmd.len      = held_len;
    push_cmd.bank     = wbank;
    if (b != running_crc) begin
      push_cmd.kind = KIND_CRC_ERR;
    end else if (held_len == '0) begin
      push_cmd.kind = KIND_EMPTY;
    end else begin
      push_cmd.kind = KIND_DATA;
    end
  end

  // Bank ownership bookkeeping.
  always_comb begin
    busy_set = '0;
    busy_clr = '0;
    if (push && (push_cmd.kind == KIND_DATA)) begin
      busy_set[wbank] = 1'b1;
    end
    if (bank_free.valid) begin
      busy_clr[bank_free.bank] = 1'b1;
    end
  end

  // Configuration registers and the framing state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DST;
      own_address   <= '0;
      peer_address  <= '0;
      max_payload   <= MAX_PAYLOAD_RST;
      crc_poly      <= CRC_POLY_RST;
      crc_seed      <= '0;
      held_seq      <= '0;
      held_type     <= '0;
      held_len      <= '0;
      payload_count <= '0;
      running_crc   <= '0;
      wbank         <= 1'b0;
      busy          <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          CFG_OWN_ADDR:    own_address  <= wr_data;
          CFG_PEER_ADDR:   peer_address <= wr_data;
          CFG_MAX_PAYLOAD: max_payload  <= wr_data[LenW-1:0];
          CFG_CRC_POLY:    crc_poly     <= wr_data;
          CFG_CRC_SEED:    crc_seed     <= wr_data;
          default: ;
        endcase
      end
      busy <= (busy & ~busy_clr) | busy_set;
      if (busy_set[wbank]) begin
        wbank <= ~wbank;
      end
      if (accept) begin
        unique case (phase)
          PH_SRC: begin
            phase <= (b == peer_address) ? PH_SEQ : PH_DST;
          end
          PH_SEQ: begin
            held_seq    <= b;
            running_crc <= crc_new;
            phase       <= PH_TYPE;
          end
          PH_TYPE: begin
            held_type   <= b;
            running_crc <= crc_new;
            phase       <= PH_LEN;
          end
          PH_LEN: begin
            if (b > {1'b0, limit}) begin
              phase <= PH_DST;
            end else begin
              held_len      <= b[LenW-1:0];
              running_crc   <= crc_new;
              payload_count <= '0;
              phase         <= (b == '0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            running_crc   <= crc_new;
            payload_count <= count_next;
            if (count_next >= held_len) begin
              phase <= PH_CRC;
            end
          end
          PH_CRC: begin
            phase <= PH_DST;
          end
          default: begin
            phase <= (b == own_address) ? PH_SRC : PH_DST;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/apd_queue.sv -----
// Two-entry queue of frame commands between the parser and the result side.
module apd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  apd_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          head_valid,
  output apd_pkg::cmd_t head
);
  import apd_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/apd_back.sv -----
// Result side: expands each frame command into result words.
module apd_back #(
  parameter int IW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  apd_pkg::cmd_t              head,
  output logic                       pop,
  output apd_pkg::bank_free_t        bank_free,
  output logic                       ram_re,
  output logic [IW:0]                ram_raddr,
  input  logic [apd_pkg::ByteW-1:0]  ram_rdata,
  apd_out_if.source                  result
);
  import apd_pkg::*;

  logic [IW-1:0]    idx;
  logic             pend;
  logic [KindW-1:0] st_kind;
  logic [ByteW-1:0] st_seq;
  logic [ByteW-1:0] st_type;
  logic [LenW-1:0]  st_len;
  logic [IW-1:0]    st_idx;
  logic             st_last;

  logic             out_valid;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_seq;
  logic [ByteW-1:0] out_type;
  logic [LenW-1:0]  out_len;
  logic [IdxW-1:0]  out_idx;
  logic [ByteW-1:0] out_data;
  logic             out_last;

  logic             issue;
  logic             is_last;

  // Start one result when the output register is free by the time the
  // read data comes back.
  assign issue   = head_valid && !pend && (!out_valid || result.ready);
  assign is_last = (head.kind != KIND_DATA) || ((LenW'(idx) + 1'b1) == head.len);
  assign pop     = issue && is_last;

  assign bank_free.valid = issue && is_last && (head.kind == KIND_DATA);
  assign bank_free.bank  = head.bank;

  assign ram_re    = issue;
  assign ram_raddr = {head.bank, idx};

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.seq_num     = out_seq;
  assign result.packet_type = out_type;
  assign result.payload_len = out_len;
  assign result.byte_index  = out_idx;
  assign result.data_byte   = out_data;
  assign result.last        = out_last;

  // Control: read pending flag, index counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (pend) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      if (issue) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  // Payload: stage fields alongside the RAM read, then the output register.
  always_ff @(posedge clk) begin
    if (issue) begin
      st_kind <= head.kind;
      st_seq  <= head.seq;
      st_type <= head.ptype;
      st_len  <= head.len;
      st_idx  <= idx;
      st_last <= is_last;
    end
    if (pend) begin
      out_kind <= st_kind;
      out_seq  <= st_seq;
      out_type <= st_type;
      out_len  <= st_len;
      out_idx  <= IdxW'(st_idx);
      out_data <= (st_kind == KIND_DATA) ? ram_rdata : '0;
      out_last <= st_last;
    end
  end

endmodule
